// ===== rtl/m64h_pkg.sv =====
package m64h_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_DISPATCH,
        ST_K1,
        ST_K2,
        ST_HMUL,
        ST_FIN,
        ST_EMIT
    } st_t;

    // x ^ (x >> 47)
    function automatic logic [63:0] xs47(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

// ===== rtl/murmur64_hash_engine.sv =====
// Streaming MurmurHash64A, one 64-bit word at a time, one word in flight.
// Every 64-bit multiply by M runs on one shared 32x32 multiplier as 3 partial products.
// Middle word: three multiplies from accept to accept. First word adds the length*M multiply.
// Last word: one (no tail), two (tail) or four (full) multiplies; a first word adds length*M.
// Synchronous active-low reset clears seed, accumulator, message state and output valid.
module murmur64_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_hash_seed,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic [31:0] s_message_length,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);
    import m64h_pkg::*;

    st_t         state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] word_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic [63:0] h_reg;
    logic [63:0] accum_reg;
    logic        mid_reg;
    logic        out_valid_reg;
    logic [63:0] hash_reg;

    logic        mul_start;
    logic [63:0] mul_op;
    logic        mul_done;
    logic [63:0] mul_prod;

    logic        accept;
    logic        full_word;
    logic [63:0] tail_mask;
    logic        emit_load;

    m64h_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .operand (mul_op),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    // non-last words always count as full
    assign full_word = !last_reg || cnt_reg[3];
    assign tail_mask = ~({64{1'b1}} << {cnt_reg[2:0], 3'b000});
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = mid_reg ? ST_DISPATCH : ST_LEN;
                end
            end
            ST_LEN: begin
                if (mul_done) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (full_word) begin
                    state_next = ST_K1;
                end else if (cnt_reg != 4'd0) begin
                    state_next = ST_HMUL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_K1: begin
                if (mul_done) state_next = ST_K2;
            end
            ST_K2: begin
                if (mul_done) state_next = ST_HMUL;
            end
            ST_HMUL: begin
                if (mul_done) state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (mul_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // multiplier feed
    always_comb begin
        mul_start = 1'b0;
        mul_op    = 64'b0;
        case (state_reg)
            ST_IDLE: begin
                mul_start = s_valid && !mid_reg;
                mul_op    = {32'b0, s_message_length};
            end
            ST_DISPATCH: begin
                mul_start = 1'b1;
                if (full_word) begin
                    mul_op = word_reg;
                end else if (cnt_reg != 4'd0) begin
                    mul_op = h_reg ^ (word_reg & tail_mask);
                end else begin
                    mul_op = xs47(h_reg);
                end
            end
            ST_K1: begin
                mul_start = mul_done;
                mul_op    = xs47(mul_prod);
            end
            ST_K2: begin
                mul_start = mul_done;
                mul_op    = h_reg ^ mul_prod;
            end
            ST_HMUL: begin
                mul_start = mul_done && last_reg;
                mul_op    = xs47(mul_prod);
            end
            default: begin
                mul_start = 1'b0;
                mul_op    = 64'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seed_reg      <= 64'b0;
            accum_reg     <= 64'b0;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_hash_seed;
            end
            if (state_reg == ST_HMUL && mul_done && !last_reg) begin
                accum_reg <= mul_prod;
                mid_reg   <= 1'b1;
            end
            if (emit_load) begin
                accum_reg     <= h_reg;
                mid_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= s_data_word;
            cnt_reg  <= s_byte_count;
            last_reg <= s_last_word;
            h_reg    <= accum_reg;
        end
        if (state_reg == ST_LEN && mul_done) begin
            h_reg <= seed_reg ^ mul_prod;
        end
        if (state_reg == ST_FIN && mul_done) begin
            h_reg <= xs47(mul_prod);
        end
        if (emit_load) begin
            hash_reg <= h_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_LEN || state_reg == ST_K1 || state_reg == ST_K2 ||
                      state_reg == ST_HMUL || state_reg == ST_FIN))
        else $error("multiplier finished outside a wait state");

    a_first_word_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !mid_reg) |=> state_reg == ST_LEN)
        else $error("first word did not start the length multiply");

    a_emit_ends_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> !mid_reg && m_valid)
        else $error("emitted hash without closing the message");

    a_mid_only_nonlast: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mid_reg) |-> $past(state_reg) == ST_HMUL && !$past(last_reg))
        else $error("message marked open by a last word");

endmodule

// ===== rtl/m64h_mul.sv =====
module m64h_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] product
);
    import m64h_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx, my;
    logic [63:0] pp;

    // low 64 bits of a*M = aL*ML + ((aL*MH + aH*ML) << 32), one 32x32 product a cycle
    always_comb begin
        mx = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        my = (step_reg == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
        pp = {32'b0, mx} * {32'b0, my};
        if (step_reg == 2'd0) begin
            acc_next = pp;
        end else begin
            acc_next = acc_reg + {pp[31:0], 32'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd2) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= operand;
        end
        if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) || $past(done_reg))
        else $error("done without a preceding multiply");

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg == 2'd2 && !start) |=> done_reg && !busy_reg)
        else $error("multiply did not finish after third partial product");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg != 2'd3)
        else $error("partial product step overran");

endmodule
